FILE: rtl/core/sgb_pkg.sv
package sgb_pkg;

	localparam int TAPS        = 5;
	localparam int ROWS        = TAPS - 1;
	localparam int SLOT_W      = 2;
	localparam int CH_W        = 8;
	localparam int WGT_W       = 16;
	localparam int SIZE_W      = 11;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int PROD_W      = CH_W + WGT_W;
	localparam int PROD_SHIFT  = 14;
	localparam int SUM_W       = 13;
	localparam int CNT_W       = 3;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int QUO_W       = SUM_W + RECIP_W;
	localparam int CH_MAX      = 255;

	localparam logic [WGT_W-1:0]  WEIGHT_OUTER_RST  = 16'd16358;
	localparam logic [WGT_W-1:0]  WEIGHT_NEAR_RST   = 16'd16397;
	localparam logic [WGT_W-1:0]  WEIGHT_CENTER_RST = 16'd16410;
	localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST   = 11'd640;
	localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST  = 11'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_OUTER  = 3'd0,
		REG_WEIGHT_NEAR   = 3'd1,
		REG_WEIGHT_CENTER = 3'd2,
		REG_IMAGE_WIDTH   = 3'd3,
		REG_IMAGE_HEIGHT  = 3'd4
	} reg_index_t;

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [TAPS-1:0] taps_t;
	typedef logic [TAPS-1:0] tap_ok_t;

	typedef struct packed {
		logic [WGT_W-1:0] outer;
		logic [WGT_W-1:0] near;
		logic [WGT_W-1:0] center;
	} weights_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	typedef struct packed {
		logic  drain;
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} pixel_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
		logic  frame_end;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_V0,
		ST_V1,
		ST_V2,
		ST_V3
	} state_t;

	// reciprocal of the valid tap count, exact for sums below 2^SUM_W
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			3'd1:    r = 17'd65536;
			3'd2:    r = 17'd32768;
			3'd3:    r = 17'd21846;
			3'd4:    r = 17'd16384;
			3'd5:    r = 17'd13108;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/core/sgb_stream_if.sv
interface sgb_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/sgb_lane.sv
module sgb_lane import sgb_pkg::*; (
	input  logic     clk,
	input  taps_t    taps,
	input  tap_ok_t  ok,
	input  weights_t weights,
	output chan_t    result
);

	logic [WGT_W-1:0]  wsel [TAPS];
	logic [PROD_W-1:0] prod_s1 [TAPS];
	tap_ok_t           ok_s1;
	logic [SUM_W-1:0]  sum;
	logic [CNT_W-1:0]  cnt;
	logic [SUM_W-1:0]  sum_s2;
	logic [CNT_W-1:0]  cnt_s2;
	logic [QUO_W-1:0]  quo_s3;
	logic [QUO_W-RECIP_SHIFT-1:0] mean;

	// symmetric taps: center, near pair, outer pair
	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			if (k == TAPS / 2)
				wsel[k] = weights.center;
			else if (k == TAPS / 2 - 1 || k == TAPS / 2 + 1)
				wsel[k] = weights.near;
			else
				wsel[k] = weights.outer;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < TAPS; k++)
			prod_s1[k] <= PROD_W'(taps[k]) * PROD_W'(wsel[k]);
		ok_s1 <= ok;
	end

	// sum of the floored products of the valid taps, and their count
	always_comb begin
		sum = '0;
		cnt = '0;
		for (int k = 0; k < TAPS; k++) begin
			if (ok_s1[k]) begin
				sum = sum + SUM_W'(prod_s1[k][PROD_W-1:PROD_SHIFT]);
				cnt = cnt + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= sum;
		cnt_s2 <= cnt;
		quo_s3 <= QUO_W'(sum_s2) * QUO_W'(recip(cnt_s2));
	end

	assign mean   = quo_s3[QUO_W-1:RECIP_SHIFT];
	assign result = (mean > (QUO_W-RECIP_SHIFT)'(CH_MAX)) ? chan_t'(CH_MAX) : mean[CH_W-1:0];

endmodule

FILE: rtl/core/sgb_line_store.sv
module sgb_line_store import sgb_pkg::*; #(
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output rgb_t [ROWS-1:0]   rd_data,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_slot,
	input  logic [AW-1:0]     wr_addr,
	input  rgb_t              wr_data
);

	// one bank per row slot, all read at the same column
	for (genvar b = 0; b < ROWS; b++) begin : g_bank
		rgb_t mem [DEPTH];

		always_ff @(posedge clk) begin
			if (wr_en && wr_slot == SLOT_W'(b))
				mem[wr_addr] <= wr_data;
			if (rd_en)
				rd_data[b] <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/separable_gaussian_blur_5tap_top.sv
// result path: a pixel beat that completes a blur result runs ST_H0 to ST_V3, then res_q
// throughput: the input opens again once a pixel's filter work leaves ST_V3; drain beats
//   and early beats that start no filter work leave it open; the shared lane pipeline runs
//   horizontal then vertical; a waiting result beat holds the next pixel in its last step
// reset: arst_n clears counters, window, handshake state and restores register defaults
// line store contents are not cleared and need no clearing pass
module separable_gaussian_blur_5tap_top import sgb_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sgb_stream_if.sink            pixels,
	sgb_stream_if.source          blurred,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// widths that follow from the frame limits
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
	localparam int ROW_W = $clog2(MAX_HEIGHT + 5);
	localparam int POS_W = ROW_W + WID_W + 1;
	localparam int XW    = WID_W + 2;
	localparam int RX    = ROW_W + 2;

	// configuration registers
	weights_t          weights_q;
	logic [SIZE_W-1:0] image_width_q;
	logic [SIZE_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q.outer  <= WEIGHT_OUTER_RST;
			weights_q.near   <= WEIGHT_NEAR_RST;
			weights_q.center <= WEIGHT_CENTER_RST;
			image_width_q    <= IMAGE_WIDTH_RST;
			image_height_q   <= IMAGE_HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (reg_index_t'(cfg_index))
				REG_WEIGHT_OUTER:  weights_q.outer  <= cfg_data;
				REG_WEIGHT_NEAR:   weights_q.near   <= cfg_data;
				REG_WEIGHT_CENTER: weights_q.center <= cfg_data;
				REG_IMAGE_WIDTH:   image_width_q    <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q   <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero counts as one, clamp to the limits
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;

	always_comb begin
		if (image_width_q == '0)
			w_eff = WID_W'(1);
		else if (32'(image_width_q) > MAX_WIDTH)
			w_eff = WID_W'(MAX_WIDTH);
		else
			w_eff = WID_W'(image_width_q);
		if (image_height_q == '0)
			h_eff = HGT_W'(1);
		else if (32'(image_height_q) > MAX_HEIGHT)
			h_eff = HGT_W'(MAX_HEIGHT);
		else
			h_eff = HGT_W'(image_height_q);
	end

	// stream position and the horizontal window
	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	rgb_t             row_window_q [ROWS];

	state_t state_q, state_d;

	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] area;
	logic             in_frame;
	logic             started;
	logic             in_acc;
	logic             work;
	logic             launch;
	rgb_t             cur;

	assign pixels.ready = (state_q == ST_IDLE);
	assign in_acc       = pixels.valid && pixels.ready;

	// raster index of the incoming beat against the frame area
	assign pos      = POS_W'(in_row_q) * POS_W'(w_eff) + POS_W'(in_col_q);
	assign area     = POS_W'(h_eff) * POS_W'(w_eff);
	assign in_frame = pos < area;
	assign started  = pos >= POS_W'(2);

	// a drain beat inside the frame is dropped, a pixel after the frame acts as a drain
	assign work   = in_acc && !(pixels.data.drain && in_frame);
	assign launch = work && started;

	always_comb begin
		if (in_frame) begin
			cur.red   = pixels.data.red_in;
			cur.green = pixels.data.green_in;
			cur.blue  = pixels.data.blue_in;
		end else begin
			cur = '0;
		end
	end

	// tap validity at the horizontal and vertical result positions
	logic [XW-1:0] hc_x;
	logic [XW-1:0] w_x;
	logic [RX-1:0] or_x;
	logic [RX-1:0] h_x;
	tap_ok_t       hok;
	tap_ok_t       vok;
	logic          vvalid;
	logic          fend;

	assign hc_x = XW'(out_col_q);
	assign w_x  = XW'(w_eff);
	assign or_x = RX'(out_row_q);
	assign h_x  = RX'(h_eff);

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			hok[k] = (hc_x + XW'(k) >= XW'(2)) && (hc_x + XW'(k) - XW'(2) < w_x);
			vok[k] = (or_x + RX'(k) >= RX'(4)) && (or_x + RX'(k) - RX'(4) < h_x);
		end
	end

	assign vvalid = (or_x >= RX'(2)) && (or_x - RX'(2) < h_x) && (hc_x < w_x);
	assign fend   = vvalid && (or_x - RX'(2) == h_x - RX'(1)) && (hc_x == w_x - XW'(1));

	// next positions, wrapping at the row end
	logic [COL_W-1:0] in_col_nx;
	logic [ROW_W-1:0] in_row_nx;
	logic [COL_W-1:0] out_col_nx;
	logic [ROW_W-1:0] out_row_nx;
	logic             clr;

	always_comb begin
		if (XW'(in_col_q) + XW'(1) >= w_x) begin
			in_col_nx = '0;
			in_row_nx = in_row_q + ROW_W'(1);
		end else begin
			in_col_nx = in_col_q + COL_W'(1);
			in_row_nx = in_row_q;
		end
		out_col_nx = out_col_q;
		out_row_nx = out_row_q;
		if (started) begin
			if (hc_x + XW'(1) >= w_x) begin
				out_col_nx = '0;
				out_row_nx = out_row_q + ROW_W'(1);
			end else begin
				out_col_nx = out_col_q + COL_W'(1);
			end
		end
		// end of frame, or a frame abandoned after a size change
		clr = (started && fend) || (RX'(out_row_nx) > h_x + RX'(1))
			|| (RX'(in_row_nx) > h_x + RX'(3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			for (int k = 0; k < ROWS; k++)
				row_window_q[k] <= '0;
		end else if (work) begin
			for (int k = 0; k < ROWS - 1; k++)
				row_window_q[k] <= row_window_q[k + 1];
			row_window_q[ROWS-1] <= cur;
			if (clr) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				in_col_q  <= in_col_nx;
				in_row_q  <= in_row_nx;
				out_col_q <= out_col_nx;
				out_row_q <= out_row_nx;
			end
		end
	end

	// job registers for the beat in flight
	rgb_t              htaps_q [TAPS];
	tap_ok_t           hok_q;
	tap_ok_t           vok_q;
	logic              vvalid_q;
	logic              fend_q;
	logic [COL_W-1:0]  col_q;
	logic [SLOT_W-1:0] slot_q;
	rgb_t              hpix_q;

	always_ff @(posedge clk) begin
		if (launch) begin
			for (int k = 0; k < ROWS; k++)
				htaps_q[k] <= row_window_q[k];
			htaps_q[TAPS-1] <= cur;
			hok_q    <= hok;
			vok_q    <= vok;
			vvalid_q <= vvalid;
			fend_q   <= fend;
			col_q    <= out_col_q;
			slot_q   <= out_row_q[SLOT_W-1:0];
		end
	end

	// line store: horizontal results of the last four rows
	rgb_t [ROWS-1:0] line_rd;
	logic            line_wr;

	sgb_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.rd_en   (launch),
		.rd_addr (out_col_q),
		.rd_data (line_rd),
		.wr_en   (line_wr),
		.wr_slot (slot_q),
		.wr_addr (col_q),
		.wr_data (hpix_q)
	);

	// lane inputs: horizontal window first, then the column of stored rows
	logic    vphase;
	rgb_t    tap_sel [TAPS];
	tap_ok_t lane_ok;
	taps_t   red_taps;
	taps_t   green_taps;
	taps_t   blue_taps;
	chan_t   red_res;
	chan_t   green_res;
	chan_t   blue_res;

	assign vphase = (state_q == ST_V0) || (state_q == ST_V1)
		|| (state_q == ST_V2) || (state_q == ST_V3);

	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			// tap k sits in row out_row - 4 + k, slot (out_row + k) mod 4
			if (vphase)
				tap_sel[k] = line_rd[SLOT_W'(slot_q + SLOT_W'(k))];
			else
				tap_sel[k] = htaps_q[k];
		end
		tap_sel[TAPS-1] = vphase ? hpix_q : htaps_q[TAPS-1];
		lane_ok = vphase ? vok_q : hok_q;
		for (int k = 0; k < TAPS; k++) begin
			red_taps[k]   = tap_sel[k].red;
			green_taps[k] = tap_sel[k].green;
			blue_taps[k]  = tap_sel[k].blue;
		end
	end

	sgb_lane u_lane_red (
		.clk     (clk),
		.taps    (red_taps),
		.ok      (lane_ok),
		.weights (weights_q),
		.result  (red_res)
	);

	sgb_lane u_lane_green (
		.clk     (clk),
		.taps    (green_taps),
		.ok      (lane_ok),
		.weights (weights_q),
		.result  (green_res)
	);

	sgb_lane u_lane_blue (
		.clk     (clk),
		.taps    (blue_taps),
		.ok      (lane_ok),
		.weights (weights_q),
		.result  (blue_res)
	);

	// merge the lanes: the horizontal pixel, held for the store and as the newest vertical tap
	always_ff @(posedge clk) begin
		if (state_q == ST_H3) begin
			hpix_q.red   <= red_res;
			hpix_q.green <= green_res;
			hpix_q.blue  <= blue_res;
		end
	end

	// output register lets the next pixel enter while a result beat waits
	result_t res_q;
	logic    res_valid_q;
	logic    res_load;

	assign blurred.valid = res_valid_q;
	assign blurred.data  = res_q;

	always_comb begin
		state_d  = state_q;
		line_wr  = 1'b0;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: if (launch) state_d = ST_H0;
			ST_H0:   state_d = ST_H1;
			ST_H1:   state_d = ST_H2;
			ST_H2:   state_d = ST_H3;
			ST_H3:   state_d = ST_V0;
			ST_V0: begin
				line_wr = 1'b1;
				state_d = ST_V1;
			end
			ST_V1:   state_d = ST_V2;
			ST_V2:   state_d = ST_V3;
			ST_V3: begin
				if (!vvalid_q) begin
					state_d = ST_IDLE;
				end else if (!res_valid_q || blurred.ready) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (res_load)
			res_valid_q <= 1'b1;
		else if (blurred.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.red_out   <= red_res;
			res_q.green_out <= green_res;
			res_q.blue_out  <= blue_res;
			res_q.frame_end <= fend_q;
		end
	end

endmodule

FILE: rtl/core/sgb_checker.sv
module sgb_checker import sgb_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	// a result beat only appears at the end of pixel work, when input is held off
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result beat appeared while input was open");

	// back-to-back result beats need a reload from a busy cycle
	a_reload_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid || !$past(in_ready))
		else $error("result reloaded while input was open");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

endmodule

bind separable_gaussian_blur_5tap_top sgb_checker u_sgb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (blurred.valid),
	.out_ready (blurred.ready),
	.out_data  (blurred.data)
);

FILE: test/tb_separable_gaussian_blur_5tap_top.sv
module tb_separable_gaussian_blur_5tap_top;
	import sgb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 1024;
	localparam int SETTLE      = 30;     // idle margin after the last result arrives
	localparam int STALL_LIMIT = 20000;  // cycles with no beat on either side

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sgb_stream_if #(.T(pixel_t)) pixels_if ();
	sgb_stream_if #(.T(result_t)) blurred_if ();

	separable_gaussian_blur_5tap_top #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pixels_if),
		.blurred(blurred_if),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// pending input beats and blur results still owed by the block
	pixel_t pixel_queue[$];
	result_t blur_queue[$];

	// mirror of the register file
	logic [WGT_W-1:0] w_outer, w_near, w_center;
	logic [SIZE_W-1:0] width_reg, height_reg;

	// mirror of the block state
	logic [23:0] row_win[4];
	logic [23:0] hline[4*MAX_W];
	int unsigned in_col, in_row, out_col, out_row;

	int errors = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int beats_sent = 0;
	int quiet_cycles = 0;
	bit beat_taken = 0;

	initial clk = 0;
	always #10 clk = ~clk;

	// size register as the block sees it
	function automatic int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned lim);
		if (v == 0)
			return 1;
		if (v > lim)
			return lim;
		return v;
	endfunction

	// weighted 5-tap mean per channel over the valid taps, saturated
	function automatic logic [23:0] blend5(logic [4:0][23:0] tp, logic [4:0] ok);
		logic [23:0] res;
		int unsigned sum, cnt, v, wt;
		res = '0;
		for (int sh = 16; sh >= 0; sh -= 8) begin
			sum = 0;
			cnt = 0;
			for (int k = 0; k < 5; k++) begin
				if (!ok[k])
					continue;
				wt = (k == 2) ? w_center : ((k == 1 || k == 3) ? w_near : w_outer);
				sum += (((tp[k] >> sh) & 32'hFF) * wt) >> 14;
				cnt++;
			end
			v = cnt ? sum / cnt : 0;
			if (v > CH_MAX)
				v = CH_MAX;
			res |= 24'(v << sh);
		end
		return res;
	endfunction

	// advance the mirror by one accepted beat, queue the blur result it yields
	task automatic predict_blur(pixel_t px);
		int unsigned w, h, n;
		bit in_frame, fe;
		logic [23:0] cur, hpix, v;
		logic [4:0][23:0] tp;
		logic [4:0] ok;
		int col, vr, row;
		result_t r;
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		n = in_row * w + in_col;
		in_frame = n < h * w;
		fe = 0;
		// drain beat inside the frame is dropped without effect
		if (px.drain && in_frame)
			return;
		cur = in_frame ? {px.red_in, px.green_in, px.blue_in} : 24'h0;
		if (n >= 2) begin
			for (int k = 0; k < 5; k++) begin
				col = int'(out_col) - 2 + k;
				tp[k] = (k < 4) ? row_win[k] : cur;
				ok[k] = col >= 0 && col < int'(w);
			end
			hpix = blend5(tp, ok);
			vr = int'(out_row) - 2;
			if (vr >= 0 && vr < int'(h) && out_col < w) begin
				for (int k = 0; k < 5; k++) begin
					row = vr - 2 + k;
					ok[k] = row >= 0 && row < int'(h);
					if (k < 4)
						tp[k] = ok[k] ? hline[(row & 3) * MAX_W + out_col] : 24'h0;
					else
						tp[k] = hpix;
				end
				v = blend5(tp, ok);
				fe = vr == int'(h) - 1 && out_col == w - 1;
				r.red_out = v[23:16];
				r.green_out = v[15:8];
				r.blue_out = v[7:0];
				r.frame_end = fe;
				blur_queue.push_back(r);
			end
			if (out_col < MAX_W)
				hline[(out_row & 3) * MAX_W + out_col] = hpix;
			if (out_col + 1 >= w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
		end
		for (int k = 0; k < 3; k++)
			row_win[k] = row_win[k+1];
		row_win[3] = cur;
		if (in_col + 1 >= w) begin
			in_col = 0;
			in_row++;
		end else begin
			in_col++;
		end
		// frame end, or a frame that ran past its last row, restarts the counters
		if (fe || out_row > h + 1 || in_row > h + 3) begin
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		end
	endtask

	// input side: predict on each accepted beat; output side: check against the oldest
	always @(posedge clk) begin
		result_t exp_r;
		result_t got;
		beat_taken = pixels_if.valid && pixels_if.ready;
		if (beat_taken)
			predict_blur(pixels_if.data);
		if (blurred_if.valid && blurred_if.ready) begin
			got = blurred_if.data;
			if (blur_queue.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			end else begin
				exp_r = blur_queue.pop_front();
				if (got.red_out !== exp_r.red_out || got.green_out !== exp_r.green_out ||
				    got.blue_out !== exp_r.blue_out || got.frame_end !== exp_r.frame_end) begin
					errors++;
					$display({"%0t: mismatch, expected r %0d g %0d b %0d end %0d,",
						" actual r %0d g %0d b %0d end %0d"},
						$time, exp_r.red_out, exp_r.green_out, exp_r.blue_out,
						exp_r.frame_end, got.red_out, got.green_out, got.blue_out,
						got.frame_end);
				end
			end
		end
		// watchdog on forward progress
		if (beat_taken || (blurred_if.valid && blurred_if.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("separable_gaussian_blur_5tap_top regression: fail");
			$finish;
		end
	end

	// pixel driver: holds a beat until taken, then maybe loads the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			pixels_if.valid <= 1'b0;
		end else if (!pixels_if.valid || beat_taken) begin
			if (pixel_queue.size() > 0 && $urandom_range(99) >= send_pct) begin
				pixels_if.data <= pixel_queue.pop_front();
				pixels_if.valid <= 1'b1;
			end else begin
				pixels_if.valid <= 1'b0;
			end
		end
	end

	// result receiver back-pressure
	always @(negedge clk)
		blurred_if.ready <= ($urandom_range(99) >= recv_pct);

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_WEIGHT_OUTER:  w_outer = val;
			REG_WEIGHT_NEAR:   w_near = val;
			REG_WEIGHT_CENTER: w_center = val;
			REG_IMAGE_WIDTH:   width_reg = val[SIZE_W-1:0];
			REG_IMAGE_HEIGHT:  height_reg = val[SIZE_W-1:0];
			default: ;
		endcase
	endtask

	// wait until every beat is sent and every result has arrived, plus latency
	task automatic settle();
		do begin
			@(negedge clk);
			#1;
		end while (pixel_queue.size() != 0 || pixels_if.valid || blur_queue.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// channel value biased toward the extremes
	function automatic chan_t pick_chan();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			default: return chan_t'($urandom_range(255));
		endcase
	endfunction

	function automatic pixel_t make_beat(bit drain);
		pixel_t p;
		p.drain = drain;
		p.red_in = pick_chan();
		p.green_in = pick_chan();
		p.blue_in = pick_chan();
		return p;
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return WGT_W'(16384 + $urandom_range(64) - 32);
			default: return WGT_W'($urandom_range(65535));
		endcase
	endfunction

	// one whole frame: pixels with stray drains, then the flush beats
	task automatic run_frame(int unsigned wr, int unsigned hr, logic [WGT_W-1:0] wo,
		logic [WGT_W-1:0] wn, logic [WGT_W-1:0] wc, bit noisy, bit pause_mid);
		int unsigned w, h;
		write_reg(REG_WEIGHT_OUTER, wo);
		write_reg(REG_WEIGHT_NEAR, wn);
		write_reg(REG_WEIGHT_CENTER, wc);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(wr));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(hr));
		w = clamp_size(width_reg, MAX_W);
		h = clamp_size(height_reg, MAX_H);
		for (int unsigned i = 0; i < h * w; i++) begin
			// drain inside the frame must be ignored
			if (noisy && $urandom_range(9) == 0) begin
				pixel_queue.push_back(make_beat(1'b1));
				beats_sent++;
			end
			pixel_queue.push_back(make_beat(1'b0));
			beats_sent++;
			// sender holds off until the block has caught up
			if (pause_mid && i == (h * w) / 2)
				settle();
		end
		// a pixel during the flush counts as a drain; the last beat ends the frame
		for (int unsigned j = 0; j < 2 * w + 2; j++) begin
			pixel_queue.push_back(make_beat(!(noisy && j < 2 * w + 1 &&
				$urandom_range(7) == 0)));
			beats_sent++;
		end
		settle();
	endtask

	initial begin
		bit paused;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pixels_if.valid = 1'b0;
		pixels_if.data = '0;
		blurred_if.ready = 1'b0;
		w_outer = WEIGHT_OUTER_RST;
		w_near = WEIGHT_NEAR_RST;
		w_center = WEIGHT_CENTER_RST;
		width_reg = IMAGE_WIDTH_RST;
		height_reg = IMAGE_HEIGHT_RST;
		for (int k = 0; k < 4; k++)
			row_win[k] = '0;
		for (int k = 0; k < 4 * MAX_W; k++)
			hline[k] = '0;
		in_col = 0;
		in_row = 0;
		out_col = 0;
		out_row = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// receiver idles more than the sender first
		send_pct = 38;
		recv_pct = 71;

		// directed: saturating weights, a single pixel frame with zero weights, reset weights
		run_frame(3, 2, '1, '1, '1, 1'b1, 1'b0);
		run_frame(1, 1, '0, '0, '0, 1'b0, 1'b0);
		run_frame(2, 3, WEIGHT_OUTER_RST, WEIGHT_NEAR_RST, WEIGHT_CENTER_RST, 1'b1, 1'b0);

		// size extremes: a zero size register counts as one
		run_frame(0, 3, pick_weight(), pick_weight(), pick_weight(), 1'b1, 1'b0);
		run_frame(3, 0, pick_weight(), pick_weight(), pick_weight(), 1'b1, 1'b0);

		// random small frames
		paused = 0;
		beats_sent = 0;
		while (beats_sent < 1000) begin
			if (beats_sent >= 660) begin
				send_pct = 0;
				recv_pct = 0;
			end else if (beats_sent >= 330) begin
				send_pct = 71;
				recv_pct = 38;
			end
			run_frame($urandom_range(9, 1), $urandom_range(7, 1), pick_weight(),
				pick_weight(), pick_weight(), $urandom_range(3) != 0,
				!paused && beats_sent > 100);
			if (beats_sent > 100)
				paused = 1;
		end

		settle();
		if (errors == 0)
			$display("separable_gaussian_blur_5tap_top regression: pass");
		else
			$display("separable_gaussian_blur_5tap_top regression: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sgb_pkg.sv
rtl/core/sgb_stream_if.sv
rtl/core/sgb_lane.sv
rtl/core/sgb_line_store.sv
rtl/core/separable_gaussian_blur_5tap_top.sv
rtl/core/sgb_checker.sv
test/tb_separable_gaussian_blur_5tap_top.sv
